>>> rtl/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Shared widths, register indexes, reset values and payload types of the
// escape-time colouriser.
// ----------------------------------------------------------------------------
package mec_pkg;

	localparam int PIX_W      = 10;
	localparam int COORD_W    = 48;
	localparam int STEP_W     = 47;
	localparam int CUT_W      = 8;
	localparam int LIM_W      = 16;
	localparam int COL_W      = 8;
	localparam int FRAC_W     = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam int IMAGE_SIZE_DEF = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_START_REAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_IMAG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 3'd4;

	localparam logic [COORD_W-1:0] START_REAL_RST = -48'sd10737418240;
	localparam logic [COORD_W-1:0] START_IMAG_RST = -48'sd8589934592;
	localparam logic [STEP_W-1:0]  STEP_RST       = 47'd16777216;
	localparam logic [CUT_W-1:0]   CUTOFF_RST     = 8'd100;
	localparam logic [LIM_W-1:0]   LIMIT_RST      = 16'd100;

	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 20;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int DIV_NUM_W = 24;
	localparam int DIV_DEN_W = LIM_W;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} pix_req_t;

	typedef struct packed {
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
		logic [LIM_W-1:0] iterations;
		logic             inside_res;
	} pix_res_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
		logic [DIV_DEN_W-1:0] rem;
	} div_rsp_t;

endpackage

>>> rtl/mec_mul.sv
// ----------------------------------------------------------------------------
// mec_mul
// Shared unsigned multiplier with a registered product, used for the pixel
// offsets and for the partial products of every squaring.
// ----------------------------------------------------------------------------
module mec_mul (
	input  logic                        clk,
	input  logic [mec_pkg::MUL_A_W-1:0] a,
	input  logic [mec_pkg::MUL_B_W-1:0] b,
	output logic [mec_pkg::MUL_P_W-1:0] p_q
);
	import mec_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

>>> rtl/mec_div.sv
// ----------------------------------------------------------------------------
// mec_div
// Restoring divider, one quotient bit per cycle, with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module mec_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mec_pkg::DIV_NUM_W-1:0] num,
	input  logic [mec_pkg::DIV_DEN_W-1:0] den,
	output mec_pkg::div_rsp_t             rsp
);
	import mec_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic                 running_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] quot_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	always_comb begin
		trial = {rem_q, quot_q[DIV_NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= CNT_W'(DIV_NUM_W);
			end else if (running_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (running_q) begin
			quot_q <= {quot_q[DIV_NUM_W-2:0], fits};
			rem_q  <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

>>> rtl/mandelbrot_escape_colorizer_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_colorizer_unit
// Escape-time evaluation of one pixel in Q16.32 with an exact escape test,
// followed by a six-segment hue ramp for points outside the set.
//
//   channel   handshake              payload    direction
//   command   start, busy            request    in
//   result    done (one-cycle pulse) result     out
//   config    cfg_valid, cfg_ready   cfg_index, cfg_data  in
//
// Each iteration runs six 48x20 partial products through the one shared
// multiplier. A point that escapes then takes two passes of the bit-serial
// divider, and an IMAGE_SIZE below 1024 adds an index wrap. busy goes high
// after acceptance and falls in the same cycle as done rises; done cannot be
// held off. Reset loads the register defaults and returns to idle; cfg_ready
// is always high.
// ----------------------------------------------------------------------------
module mandelbrot_escape_colorizer_unit #(
	parameter int IMAGE_SIZE = mec_pkg::IMAGE_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  mec_pkg::pix_req_t              request,
	output logic                           done,
	output mec_pkg::pix_res_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mec_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mec_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mec_pkg::*;

	localparam int  Z_W      = 60;
	localparam int  HALF_W   = MUL_B_W;
	localparam int  MAG_W    = 2 * HALF_W;
	localparam int  PP_W     = MAG_W + HALF_W;
	localparam int  SQ_W     = 2 * MAG_W;
	localparam int  SUM_W    = SQ_W + 1;
	localparam int  RE_W     = SUM_W - FRAC_W;
	localparam int  IM_W     = SUM_W + 1 - FRAC_W;
	localparam int  CPROD_W  = STEP_W + PIX_W;
	localparam int  CUT2_W   = 2 * CUT_W;
	localparam int  WRAP_W   = 2 * PIX_W;
	localparam int  SH_W     = $clog2(PIX_W);
	localparam bit  WRAP_NEEDED = IMAGE_SIZE < (1 << PIX_W);
	localparam logic [WRAP_W-1:0] WRAP_MOD = WRAP_W'(IMAGE_SIZE);
	localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

	typedef enum logic [4:0] {
		S_IDLE, S_WRAP, S_CR, S_CI, S_CEND,
		S_CHECK, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_ESC, S_UPD,
		S_DIVK, S_DIVK_W, S_DIVU, S_DIVU_W
	} state_t;

	typedef enum logic [2:0] {
		SEG_RED_RISE, SEG_GREEN_RISE, SEG_RED_FALL,
		SEG_BLUE_RISE, SEG_GREEN_FALL, SEG_MAGENTA
	} hue_seg_t;

	state_t   state_q;
	logic     done_q;
	pix_res_t res_q;

	logic [COORD_W-1:0] start_real_q;
	logic [COORD_W-1:0] start_imag_q;
	logic [STEP_W-1:0]  step_q;
	logic [CUT_W-1:0]   cutoff_q;
	logic [LIM_W-1:0]   limit_q;

	logic [PIX_W-1:0]  px_q;
	logic [PIX_W-1:0]  py_q;
	logic [SH_W-1:0]   wrap_sh_q;
	logic [CUT2_W-1:0] cut2_q;
	logic [Z_W-1:0]    cr_q;
	logic [Z_W-1:0]    ci_q;
	logic [Z_W-1:0]    zr_q;
	logic [Z_W-1:0]    zi_q;
	logic [LIM_W-1:0]  n_q;
	logic [MAG_W-1:0]  mag_re_q;
	logic [MAG_W-1:0]  mag_im_q;
	logic              neg_q;
	logic [SQ_W-1:0]   rr_q;
	logic [SQ_W-1:0]   ii_q;
	logic [SQ_W-1:0]   ri_q;
	logic [RE_W-1:0]   re_q;
	logic [IM_W-1:0]   im_q;
	hue_seg_t          seg_q;
	logic [LIM_W-1:0]  s_q;

	logic                 accept;
	logic [WRAP_W-1:0]    wrap_div;
	logic [Z_W-1:0]       mag_re_full;
	logic [Z_W-1:0]       mag_im_full;
	logic                 big;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [MUL_P_W-1:0]   mul_p;
	logic [SUM_W-1:0]     sq_sum;
	logic [SUM_W-1:0]     sq_diff;
	logic [SUM_W-1:0]     cut_thr;
	logic                 escaped;
	logic [SUM_W:0]       cross_prod;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	div_rsp_t             div_rsp;
	logic [COL_W-1:0]     up_val;
	logic [COL_W-1:0]     dn_val;
	logic [COL_W-1:0]     hue_r;
	logic [COL_W-1:0]     hue_g;
	logic [COL_W-1:0]     hue_b;

	assign busy      = state_q != S_IDLE;
	assign accept    = start && !busy;
	assign done      = done_q;
	assign result    = res_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_real_q <= START_REAL_RST;
			start_imag_q <= START_IMAG_RST;
			step_q       <= STEP_RST;
			cutoff_q     <= CUTOFF_RST;
			limit_q      <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_REAL: start_real_q <= cfg_data[COORD_W-1:0];
				REG_START_IMAG: start_imag_q <= cfg_data[COORD_W-1:0];
				REG_STEP:       step_q       <= cfg_data[STEP_W-1:0];
				REG_CUTOFF:     cutoff_q     <= cfg_data[CUT_W-1:0];
				REG_LIMIT:      limit_q      <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		wrap_div = WRAP_MOD << wrap_sh_q;

		mag_re_full = zr_q[Z_W-1] ? (~zr_q + 1'b1) : zr_q;
		mag_im_full = zi_q[Z_W-1] ? (~zi_q + 1'b1) : zi_q;
		big = (|mag_re_full[Z_W-1:MAG_W]) || (|mag_im_full[Z_W-1:MAG_W]);

		sq_sum     = {1'b0, rr_q} + {1'b0, ii_q};
		sq_diff    = {1'b0, rr_q} - {1'b0, ii_q};
		cut_thr    = SUM_W'({cut2_q, {(2 * FRAC_W){1'b0}}});
		escaped    = sq_sum > cut_thr;
		cross_prod = neg_q ? (~{1'b0, ri_q, 1'b0} + 1'b1) : {1'b0, ri_q, 1'b0};
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_CR: begin
				mul_a = MUL_A_W'(step_q);
				mul_b = MUL_B_W'(px_q);
			end
			S_CI: begin
				mul_a = MUL_A_W'(step_q);
				mul_b = MUL_B_W'(py_q);
			end
			S_M0: begin
				mul_a = MUL_A_W'(mag_re_q);
				mul_b = mag_re_q[HALF_W-1:0];
			end
			S_M1: begin
				mul_a = MUL_A_W'(mag_re_q);
				mul_b = mag_re_q[MAG_W-1:HALF_W];
			end
			S_M2: begin
				mul_a = MUL_A_W'(mag_im_q);
				mul_b = mag_im_q[HALF_W-1:0];
			end
			S_M3: begin
				mul_a = MUL_A_W'(mag_im_q);
				mul_b = mag_im_q[MAG_W-1:HALF_W];
			end
			S_M4: begin
				mul_a = MUL_A_W'(mag_re_q);
				mul_b = mag_im_q[HALF_W-1:0];
			end
			S_M5: begin
				mul_a = MUL_A_W'(mag_re_q);
				mul_b = mag_im_q[MAG_W-1:HALF_W];
			end
			default: ;
		endcase
	end

	mec_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = limit_q;
		unique case (state_q)
			S_DIVK: begin
				div_start = 1'b1;
				div_num   = (DIV_NUM_W'(n_q) << 2) + (DIV_NUM_W'(n_q) << 1);
			end
			S_DIVU: begin
				div_start = 1'b1;
				div_num   = (DIV_NUM_W'(s_q) << COL_W) - DIV_NUM_W'(s_q);
			end
			default: ;
		endcase
	end

	mec_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.rsp    (div_rsp)
	);

	// The falling ramp is 255 minus the rising ramp rounded up.
	always_comb begin
		up_val = div_rsp.quot[COL_W-1:0];
		dn_val = COL_MAX - up_val - COL_W'(div_rsp.rem != '0);
		hue_r  = '0;
		hue_g  = '0;
		hue_b  = '0;
		unique case (seg_q)
			SEG_RED_RISE: begin
				hue_r = up_val;
			end
			SEG_GREEN_RISE: begin
				hue_r = COL_MAX;
				hue_g = up_val;
			end
			SEG_RED_FALL: begin
				hue_r = dn_val;
				hue_g = COL_MAX;
			end
			SEG_BLUE_RISE: begin
				hue_g = COL_MAX;
				hue_b = up_val;
			end
			SEG_GREEN_FALL: begin
				hue_g = dn_val;
				hue_b = COL_MAX;
			end
			default: begin
				hue_r = up_val;
				hue_b = COL_MAX;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					px_q      <= request.pixel_x;
					py_q      <= request.pixel_y;
					wrap_sh_q <= SH_W'(PIX_W - 1);
					cut2_q    <= CUT2_W'(cutoff_q) * CUT2_W'(cutoff_q);
				end
			end
			S_WRAP: begin
				if (WRAP_W'(px_q) >= wrap_div) begin
					px_q <= px_q - wrap_div[PIX_W-1:0];
				end
				if (WRAP_W'(py_q) >= wrap_div) begin
					py_q <= py_q - wrap_div[PIX_W-1:0];
				end
				wrap_sh_q <= wrap_sh_q - 1'b1;
			end
			S_CI: begin
				cr_q <= {{(Z_W - COORD_W){start_real_q[COORD_W-1]}}, start_real_q}
					+ Z_W'(mul_p[CPROD_W-1:0]);
			end
			S_CEND: begin
				ci_q <= {{(Z_W - COORD_W){start_imag_q[COORD_W-1]}}, start_imag_q}
					+ Z_W'(mul_p[CPROD_W-1:0]);
				zr_q <= '0;
				zi_q <= '0;
				n_q  <= '0;
			end
			S_CHECK: begin
				mag_re_q <= mag_re_full[MAG_W-1:0];
				mag_im_q <= mag_im_full[MAG_W-1:0];
				neg_q    <= zr_q[Z_W-1] ^ zi_q[Z_W-1];
			end
			S_M1: rr_q <= SQ_W'(mul_p[PP_W-1:0]);
			S_M2: rr_q <= rr_q + {mul_p[PP_W-1:0], {HALF_W{1'b0}}};
			S_M3: ii_q <= SQ_W'(mul_p[PP_W-1:0]);
			S_M4: ii_q <= ii_q + {mul_p[PP_W-1:0], {HALF_W{1'b0}}};
			S_M5: ri_q <= SQ_W'(mul_p[PP_W-1:0]);
			S_M6: ri_q <= ri_q + {mul_p[PP_W-1:0], {HALF_W{1'b0}}};
			S_ESC: begin
				re_q <= sq_diff[SUM_W-1:FRAC_W];
				im_q <= cross_prod[SUM_W:FRAC_W];
			end
			S_UPD: begin
				zr_q <= cr_q + {{(Z_W - RE_W){re_q[RE_W-1]}}, re_q};
				zi_q <= ci_q + {{(Z_W - IM_W){im_q[IM_W-1]}}, im_q};
				n_q  <= n_q + 1'b1;
			end
			S_DIVK_W: begin
				if (div_rsp.done) begin
					seg_q <= hue_seg_t'(div_rsp.quot[2:0]);
					s_q   <= div_rsp.rem;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= WRAP_NEEDED ? S_WRAP : S_CR;
					end
				end
				S_WRAP:   if (wrap_sh_q == '0) state_q <= S_CR;
				S_CR:     state_q <= S_CI;
				S_CI:     state_q <= S_CEND;
				S_CEND:   state_q <= S_CHECK;
				S_CHECK: begin
					if (n_q >= limit_q) begin
						res_q   <= pix_res_t'{red: '0, green: '0, blue: '0,
							iterations: n_q, inside_res: 1'b1};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (big) begin
						state_q <= S_DIVK;
					end else begin
						state_q <= S_M0;
					end
				end
				S_M0:  state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_M4;
				S_M4:  state_q <= S_M5;
				S_M5:  state_q <= S_M6;
				S_M6:  state_q <= S_ESC;
				S_ESC: state_q <= escaped ? S_DIVK : S_UPD;
				S_UPD: state_q <= S_CHECK;
				S_DIVK:   state_q <= S_DIVK_W;
				S_DIVK_W: if (div_rsp.done) state_q <= S_DIVU;
				S_DIVU:   state_q <= S_DIVU_W;
				S_DIVU_W: begin
					if (div_rsp.done) begin
						res_q   <= pix_res_t'{red: hue_r, green: hue_g, blue: hue_b,
							iterations: n_q, inside_res: 1'b0};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> verif/tb_mandelbrot_escape_colorizer_unit.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_colorizer_unit
// Self-checking bench for the escape-time colouriser. Each accepted pixel
// request is evaluated by a bit-exact Q16.32 escape-time predictor, and the
// colour, count and inside flag it gives are queued. Every done strobe is
// compared field by field with the oldest entry. Directed requests cover the
// register extremes and the corner cases; random phases then reprogram the
// view and feed pixels in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_colorizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mec_pkg::*;

	localparam int     WATCHDOG_CYCLES = 20000;
	localparam int     SETTLE_CYCLES   = 200;
	localparam int     RANDOM_PHASES   = 11;
	localparam int     PHASE_PIXELS    = 50;
	localparam longint ONE             = longint'(1) << FRAC_W;
	localparam longint BIG_MAG         = longint'(256) << FRAC_W;
	localparam longint COORD_MAX       = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint COORD_MIN       = -(longint'(1) << (COORD_W - 1));

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum int {
		HUE_RED_RISE,
		HUE_GREEN_RISE,
		HUE_RED_FALL,
		HUE_BLUE_RISE,
		HUE_GREEN_FALL,
		HUE_RED_RETURN
	} hue_seg_e;

	class pixel_scoreboard;
		longint           re_origin;
		longint           im_origin;
		longint           pitch;
		logic [CUT_W-1:0] cutoff;
		logic [LIM_W-1:0] limit;
		pix_res_t         pending_colours[$];
		int               mismatches;

		function new();
			re_origin  = longint'($signed(START_REAL_RST));
			im_origin  = longint'($signed(START_IMAG_RST));
			pitch      = longint'(STEP_RST);
			cutoff     = CUTOFF_RST;
			limit      = LIMIT_RST;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_START_REAL: re_origin = longint'($signed(data));
				REG_START_IMAG: im_origin = longint'($signed(data));
				REG_STEP:       pitch     = longint'(data[STEP_W-1:0]);
				REG_CUTOFF:     cutoff    = data[CUT_W-1:0];
				REG_LIMIT:      limit     = data[LIM_W-1:0];
				default: ;
			endcase
		endfunction

		function pix_res_t colour_of_pixel(pix_req_t px);
			longint              cr, ci, zr, zi;
			logic signed [127:0] wr, wi, rr, ii, bound, diff, xprod;
			int unsigned         n, lim, six, k, s, up, dn, r, g, b;
			pix_res_t            res;
			cr = re_origin + longint'(px.pixel_x % IMAGE_SIZE_DEF) * pitch;
			ci = im_origin + longint'(px.pixel_y % IMAGE_SIZE_DEF) * pitch;
			lim = limit;
			bound = '0;
			bound[95:64] = cutoff * cutoff;
			zr = 0;
			zi = 0;
			n = 0;
			r = 0;
			g = 0;
			b = 0;
			while (n < lim) begin
				if (zr >= BIG_MAG || zr <= -BIG_MAG || zi >= BIG_MAG || zi <= -BIG_MAG)
					break;
				wr = zr;
				wi = zi;
				rr = wr * wr;
				ii = wi * wi;
				if (rr + ii > bound)
					break;
				diff = (rr - ii) >>> FRAC_W;
				xprod = (wr * wi) >>> (FRAC_W - 1);
				zr = longint'(diff[63:0]) + cr;
				zi = longint'(xprod[63:0]) + ci;
				n++;
			end
			if (n < lim) begin
				six = 6 * n;
				k = six / lim;
				s = six - k * lim;
				up = (255 * s) / lim;
				dn = (255 * (lim - s)) / lim;
				case (hue_seg_e'(k))
					HUE_RED_RISE: begin
						r = up;  g = 0;   b = 0;
					end
					HUE_GREEN_RISE: begin
						r = 255; g = up;  b = 0;
					end
					HUE_RED_FALL: begin
						r = dn;  g = 255; b = 0;
					end
					HUE_BLUE_RISE: begin
						r = 0;   g = 255; b = up;
					end
					HUE_GREEN_FALL: begin
						r = 0;   g = dn;  b = 255;
					end
					default: begin
						r = up;  g = 0;   b = 255;
					end
				endcase
			end
			res.red        = COL_W'(r);
			res.green      = COL_W'(g);
			res.blue       = COL_W'(b);
			res.iterations = LIM_W'(n);
			res.inside_res = (n >= lim);
			return res;
		endfunction

		function void note_request(pix_req_t px);
			pending_colours.push_back(colour_of_pixel(px));
		endfunction

		function void check_result(pix_res_t got);
			pix_res_t want;
			if (pending_colours.size() == 0) begin
				$error("result with no request outstanding: red %0d green %0d blue %0d %s %0d %s %0d",
					got.red, got.green, got.blue, "iterations", got.iterations,
					"inside_res", got.inside_res);
				mismatches++;
				return;
			end
			want = pending_colours.pop_front();
			if (got.red !== want.red) begin
				$error("red: expected %0d, got %0d", want.red, got.red);
				mismatches++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, got %0d", want.green, got.green);
				mismatches++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, got %0d", want.blue, got.blue);
				mismatches++;
			end
			if (got.iterations !== want.iterations) begin
				$error("iterations: expected %0d, got %0d", want.iterations, got.iterations);
				mismatches++;
			end
			if (got.inside_res !== want.inside_res) begin
				$error("inside_res: expected %0d, got %0d", want.inside_res, got.inside_res);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	pix_req_t              request   = '0;
	logic                  done;
	pix_res_t              result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	int                    idle_cycles = 0;
	pixel_scoreboard       sb;

	mandelbrot_escape_colorizer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("mandelbrot_escape_colorizer_unit verification failed");
				$finish;
			end
		end
	end

	function automatic pix_req_t pix(int x, int y);
		pix_req_t p;
		p.pixel_x = PIX_W'(x);
		p.pixel_y = PIX_W'(y);
		return p;
	endfunction

	function automatic longint rand_between(longint lo, longint hi);
		logic [63:0] span;
		logic [63:0] r;
		span = hi - lo + 1;
		r = {$urandom, $urandom};
		return lo + longint'(r % span);
	endfunction

	task automatic send_pixel(input pix_req_t px, input bit hold);
		start   <= 1'b1;
		request <= px;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sb.note_request(px);
		if (!hold)
			start <= 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
			input bit hold);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		sb.set_reg(idx, data);
		if (!hold)
			cfg_valid <= 1'b0;
	endtask

	task automatic program_regs(input longint sr, input longint si, input longint st,
			input int cut, input int lim);
		write_reg(REG_START_REAL, CFG_DATA_W'(sr), 1'b1);
		write_reg(REG_START_IMAG, CFG_DATA_W'(si), 1'b1);
		write_reg(REG_STEP, CFG_DATA_W'(st), 1'b1);
		write_reg(REG_CUTOFF, CFG_DATA_W'(cut), 1'b1);
		write_reg(REG_LIMIT, CFG_DATA_W'(lim), 1'b0);
	endtask

	task automatic feed_pixels(input pix_req_t list[$]);
		int burst_left;
		int gap;
		bit last;
		burst_left = $urandom_range(1, 8);
		foreach (list[i]) begin
			last = (i == list.size() - 1);
			burst_left--;
			send_pixel(list[i], !last && burst_left > 0);
			if (!last && burst_left <= 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 6);
					6, 7, 8:          gap = $urandom_range(7, 60);
					default:          gap = $urandom_range(61, 400);
				endcase
				repeat (gap)
					@(posedge clk);
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40)
					: $urandom_range(1, 6);
			end
		end
		while (sb.pending_colours.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		pix_req_t batch[$];
		longint   sr, si, st;
		int       cut, lim;
		sb = new();
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		batch = {pix(0, 0), pix(1023, 1023), pix(640, 512), pix(384, 512),
			pix('h2AA, 'h155), pix('h155, 'h2AA), pix(576, 640)};
		feed_pixels(batch);

		write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}), 1'b1);
		write_reg(REG_CUTOFF, '0, 1'b0);
		batch = {pix(640, 512), pix(700, 512)};
		feed_pixels(batch);

		write_reg(REG_LIMIT, '0, 1'b0);
		batch = {pix(640, 512), pix(0, 0)};
		feed_pixels(batch);

		write_reg(REG_CUTOFF, CFG_DATA_W'(1), 1'b1);
		write_reg(REG_LIMIT, CFG_DATA_W'(1), 1'b0);
		batch = {pix(640, 512), pix(1023, 0)};
		feed_pixels(batch);

		program_regs(COORD_MAX, COORD_MIN, 64'hFFFF_FFFF_FFFF, 128, 65535);
		batch = {pix(0, 0), pix(1023, 1023)};
		feed_pixels(batch);

		program_regs(2 * ONE, 0, 0, 255, 65535);
		batch = {pix(5, 5), pix(1023, 0)};
		feed_pixels(batch);

		program_regs(COORD_MIN, COORD_MAX, 1, 1, 1000);
		batch = {pix(0, 1023)};
		feed_pixels(batch);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if ($urandom_range(0, 3) == 0) begin
				sr  = rand_between(2 * ONE, COORD_MAX);
				si  = longint'({$urandom, $urandom});
				st  = longint'({$urandom, $urandom});
				cut = $urandom_range(0, 255);
				lim = $urandom_range(0, 65535);
			end else begin
				sr = rand_between(-(5 * ONE) / 2, ONE);
				si = rand_between(-2 * ONE, ONE);
				case ($urandom_range(0, 2))
					0:       st = rand_between(ONE >> 10, ONE >> 8);
					1:       st = rand_between(0, ONE >> 12);
					default: st = $urandom_range(0, 255);
				endcase
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
					: $urandom_range(2, 128);
				case ($urandom_range(0, 7))
					0:       lim = $urandom_range(1, 8);
					1:       lim = $urandom_range(121, 250);
					default: lim = $urandom_range(1, 120);
				endcase
			end
			program_regs(sr, si, st, cut, lim);
			batch.delete();
			repeat (PHASE_PIXELS)
				batch.push_back(pix($urandom_range(0, 1023), $urandom_range(0, 1023)));
			feed_pixels(batch);
		end

		repeat (SETTLE_CYCLES)
			@(negedge clk);
		if (sb.mismatches == 0)
			$display("mandelbrot_escape_colorizer_unit verification clean");
		else
			$display("mandelbrot_escape_colorizer_unit verification failed");
		$finish;
	end

endmodule
